>>> hdl/seu_pkg.sv
// Package for the string escape to UTF-8 decoder.
// Holds decode phase, status and character codes, the state and group types, and hex lookup.
// No dependencies.
package seu_pkg;

    // decode phases
    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_SELECT = 2'd1;
    localparam logic [1:0] PH_HEX    = 2'd2;
    localparam logic [1:0] PH_UNI    = 2'd3;

    // final status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNTERM = 2'd1;
    localparam logic [1:0] ST_BADESC = 2'd2;
    localparam logic [1:0] ST_BADUNI = 2'd3;

    // source characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_LOW_U = 8'h75;
    localparam logic [7:0] CH_UP_U = 8'h55;

    // emitted control bytes
    localparam logic [7:0] BY_LF = 8'h0A;
    localparam logic [7:0] BY_CR = 8'h0D;
    localparam logic [7:0] BY_TAB = 8'h09;
    localparam logic [7:0] BY_NUL = 8'h00;

    localparam logic [31:0] CP_SURR_LO = 32'h0000_D800;
    localparam logic [31:0] CP_SURR_HI = 32'h0000_DFFF;
    localparam logic [31:0] CP_MAX = 32'h0010_FFFF;
    localparam logic [31:0] CP_1BYTE = 32'h0000_007F;
    localparam logic [31:0] CP_2BYTE = 32'h0000_07FF;
    localparam logic [31:0] CP_3BYTE = 32'h0000_FFFF;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic        skip;
        logic [1:0]  phase;
        logic [3:0]  digits;
        logic [31:0] accum;
        logic [1:0]  err;
    } t_dec_state;

    // results caused by one source byte: up to four data bytes or one final item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last;
        logic            any;
        logic            fin;
        logic [1:0]      status;
        logic [15:0]     length;
    } t_group;

    // returns {valid, value}
    function automatic logic [4:0] f_hex(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

>>> hdl/seu_in_if.sv
// Source byte channel of the string escape decoder.
// Uses nothing outside this file.
interface seu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_end;

    modport source (output valid, output in_byte, output source_end, input ready);
    modport sink (input valid, input in_byte, input source_end, output ready);
endinterface

>>> hdl/seu_out_if.sv
// Result channel of the string escape decoder: data bytes and the final status item.
// Uses nothing outside this file.
interface seu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        end_of_literal;
    logic [1:0]  status;
    logic [15:0] decoded_length;

    modport source (output valid, output out_byte, output end_of_literal, output status,
                    output decoded_length, input ready);
    modport sink (input valid, input out_byte, input end_of_literal, input status,
                  input decoded_length, output ready);
endinterface

>>> hdl/seu_decode.sv
// Single-pass decode of one source byte: next scan state, length and result group.
// Depends on seu_pkg.
module seu_decode
    import seu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic [7:0]             i_byte,
    input  logic                   i_end,
    input  t_dec_state             i_state,
    input  logic [LENGTH_BITS-1:0] i_count,
    output t_dec_state             o_state,
    output logic [LENGTH_BITS-1:0] o_count,
    output t_group                 o_grp
);

    localparam int SW = LENGTH_BITS + 1;

    logic [4:0]       hex;
    logic [31:0]      cp;
    logic [3:0]       digits_dec;
    logic [2:0]       nbytes;
    logic [SW-1:0]    sum;
    logic [31:0]      count_ext;
    logic [1:0]       fin_status;

    assign hex = f_hex(i_byte);
    assign cp = {i_state.accum[27:0], hex[3:0]};
    assign digits_dec = i_state.digits - 4'd1;
    assign count_ext = 32'(i_count);
    assign sum = {1'b0, i_count} + SW'(nbytes);
    assign o_count = (o_grp.fin) ? '0 : (sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0]);

    always_comb begin
        o_state = i_state;
        nbytes = 3'd0;
        fin_status = ST_OK;
        o_grp = '0;
        o_grp.length = (count_ext > 32'(LEN_MAX)) ? LEN_MAX : count_ext[15:0];

        if (i_end) begin
            o_grp.fin = 1'b1;
            fin_status = ST_UNTERM;
            o_state = '0;
        end else if (!i_state.skip && i_byte == CH_QUOTE) begin
            o_grp.fin = 1'b1;
            fin_status = i_state.err;
            // digits still pending at the closing quote
            if (i_state.err == ST_OK && i_state.phase != PH_PLAIN) begin
                fin_status = ST_BADESC;
            end
            o_state = '0;
        end else begin
            o_state.skip = !i_state.skip && i_byte == CH_BSLASH;
            if (i_state.err == ST_OK) begin
                unique case (i_state.phase) inside
                    PH_PLAIN: begin
                        if (i_byte == CH_BSLASH) begin
                            o_state.phase = PH_SELECT;
                        end else begin
                            o_grp.bytes[0] = i_byte;
                            nbytes = 3'd1;
                        end
                    end
                    PH_SELECT: begin
                        o_state.phase = PH_PLAIN;
                        nbytes = 3'd1;
                        case (i_byte)
                            CH_N:      o_grp.bytes[0] = BY_LF;
                            CH_R:      o_grp.bytes[0] = BY_CR;
                            CH_T:      o_grp.bytes[0] = BY_TAB;
                            CH_BSLASH: o_grp.bytes[0] = CH_BSLASH;
                            CH_QUOTE:  o_grp.bytes[0] = CH_QUOTE;
                            CH_ZERO:   o_grp.bytes[0] = BY_NUL;
                            CH_X: begin
                                nbytes = 3'd0;
                                o_state.phase = PH_HEX;
                                o_state.digits = 4'd2;
                                o_state.accum = '0;
                            end
                            CH_LOW_U: begin
                                nbytes = 3'd0;
                                o_state.phase = PH_UNI;
                                o_state.digits = 4'd4;
                                o_state.accum = '0;
                            end
                            CH_UP_U: begin
                                nbytes = 3'd0;
                                o_state.phase = PH_UNI;
                                o_state.digits = 4'd8;
                                o_state.accum = '0;
                            end
                            default: begin
                                nbytes = 3'd0;
                                o_state.err = ST_BADESC;
                            end
                        endcase
                    end
                    PH_HEX, PH_UNI: begin
                        if (!hex[4] || i_state.digits == 4'd0) begin
                            o_state.err = ST_BADESC;
                            o_state.phase = PH_PLAIN;
                            o_state.digits = 4'd0;
                            o_state.accum = '0;
                        end else if (digits_dec != 4'd0) begin
                            o_state.accum = cp;
                            o_state.digits = digits_dec;
                        end else begin
                            o_state.digits = 4'd0;
                            o_state.phase = PH_PLAIN;
                            o_state.accum = '0;
                            if (i_state.phase == PH_HEX) begin
                                o_grp.bytes[0] = cp[7:0];
                                nbytes = 3'd1;
                            end else if ((cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
                                         cp > CP_MAX) begin
                                o_state.err = ST_BADUNI;
                            end else if (cp <= CP_1BYTE) begin
                                o_grp.bytes[0] = cp[7:0];
                                nbytes = 3'd1;
                            end else if (cp <= CP_2BYTE) begin
                                o_grp.bytes[0] = {3'b110, cp[10:6]};
                                o_grp.bytes[1] = {2'b10, cp[5:0]};
                                nbytes = 3'd2;
                            end else if (cp <= CP_3BYTE) begin
                                o_grp.bytes[0] = {4'b1110, cp[15:12]};
                                o_grp.bytes[1] = {2'b10, cp[11:6]};
                                o_grp.bytes[2] = {2'b10, cp[5:0]};
                                nbytes = 3'd3;
                            end else begin
                                o_grp.bytes[0] = {5'b11110, cp[20:18]};
                                o_grp.bytes[1] = {2'b10, cp[17:12]};
                                o_grp.bytes[2] = {2'b10, cp[11:6]};
                                o_grp.bytes[3] = {2'b10, cp[5:0]};
                                nbytes = 3'd4;
                            end
                        end
                    end
                    default: o_state = i_state;
                endcase
            end
        end

        o_grp.status = fin_status;
        if (!o_grp.fin) begin
            o_grp.length = '0;
        end
        o_grp.any = o_grp.fin || nbytes != 3'd0;
        o_grp.last = (nbytes == 3'd0) ? 2'd0 : 2'(nbytes - 3'd1);
    end

endmodule

>>> hdl/string_escape_to_utf8_decoder_top.sv
// Top level of the string escape to UTF-8 decoder: input register, decode, result group register.
// Depends on seu_pkg, seu_in_if, seu_out_if and seu_decode.
//
//  channel  | dir | payload                                            | handshake
//  i_in     | in  | in_byte[7:0], source_end                           | valid/ready
//  o_out    | out | out_byte[7:0], end_of_literal, status[1:0],        | valid/ready
//           |     | decoded_length[15:0]                               |
//
// One source byte is taken per cycle while o_out is ready and no byte yields more than one result;
// a byte that decodes to k results (k up to 4 for a four-byte UTF-8 sequence) holds the result
// register until all k are taken. A byte passes the input register, then its results the result register.
// Reset (synchronous, active low) clears the scan state, length and both valid flags.
// A stall on o_out fills the one-entry input register, then drops i_in.ready.
module string_escape_to_utf8_decoder_top
    import seu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    seu_in_if.sink   i_in,
    seu_out_if.source o_out
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_end;
    t_dec_state             r_state;
    t_dec_state             n_state;
    logic [LENGTH_BITS-1:0] r_count;
    logic [LENGTH_BITS-1:0] n_count;
    logic                   r_grp_valid;
    t_group                 r_grp;
    t_group                 n_grp;
    logic [1:0]             r_idx;
    logic                   take;
    logic                   last_take;
    logic                   move;

    seu_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .i_byte (r_in_byte),
        .i_end  (r_in_end),
        .i_state(r_state),
        .i_count(r_count),
        .o_state(n_state),
        .o_count(n_count),
        .o_grp  (n_grp)
    );

    assign take = r_grp_valid && o_out.ready;
    assign last_take = take && r_idx == r_grp.last;
    assign move = r_in_valid && (!r_grp_valid || last_take);
    assign i_in.ready = !r_in_valid || move;

    assign o_out.valid = r_grp_valid;
    assign o_out.out_byte = r_grp.fin ? 8'h00 : r_grp.bytes[r_idx];
    assign o_out.end_of_literal = r_grp.fin;
    assign o_out.status = r_grp.status;
    assign o_out.decoded_length = r_grp.length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state <= '0;
            r_count <= '0;
            r_grp_valid <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move) begin
                r_state <= n_state;
                r_count <= n_count;
                r_grp_valid <= n_grp.any;
                r_idx <= 2'd0;
            end else if (last_take) begin
                r_grp_valid <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_end <= i_in.source_end;
        end
        if (move) begin
            r_grp <= n_grp;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_valid |-> r_idx <= r_grp.last)
        else $error("result index past end of group");

    a_final_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_valid && r_grp.fin) |-> r_grp.last == 2'd0)
        else $error("final item grouped with data");

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_grp.fin) |=> (r_count == '0 && r_state.phase == PH_PLAIN &&
                                 r_state.err == ST_OK && !r_state.skip))
        else $error("scan state not cleared after final item");

    a_hold_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_valid && !o_out.ready) |=> (r_grp_valid && $stable(r_idx)))
        else $error("result group lost while stalled");
`endif

endmodule
